[src/ehd_pkg.sv]
// ----------------------------------------------------------------------------
// ehd_pkg - shared types and constants of the holy days calculator
// Widths, constant divisor codes with their reciprocals, month numbers and
// the request and response of one month walk step.
// ----------------------------------------------------------------------------
package ehd_pkg;

    // field and datapath widths
    localparam int YEAR_W      = 14;
    localparam int NUM_W       = 14;
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 24;
    localparam int QUO_W       = NUM_W + RECIP_W - RECIP_SHIFT;
    localparam int REM_W       = 9;
    localparam int DOY_W       = 8;
    localparam int DAY_W       = 5;
    localparam int MON_W       = 4;

    // register stages of the constant divider
    localparam int DIV_LAT     = 2;

    typedef logic [NUM_W-1:0] num_t;
    typedef logic [QUO_W-1:0] quo_t;
    typedef logic [REM_W-1:0] rem_t;
    typedef logic [DOY_W-1:0] doy_t;
    typedef logic [DAY_W-1:0] day_t;
    typedef logic [MON_W-1:0] mon_t;

    // month numbers
    localparam mon_t MONTH_JAN = 4'd1;
    localparam mon_t MONTH_FEB = 4'd2;
    localparam mon_t MONTH_MAR = 4'd3;
    localparam mon_t MONTH_APR = 4'd4;
    localparam mon_t MONTH_JUN = 4'd6;
    localparam mon_t MONTH_SEP = 4'd9;
    localparam mon_t MONTH_NOV = 4'd11;
    localparam mon_t MONTH_DEC = 4'd12;

    // constant divisors known to the divider
    typedef enum logic [2:0] {
        DIV_19,
        DIV_100,
        DIV_25,
        DIV_3,
        DIV_30,
        DIV_7,
        DIV_451,
        DIV_31
    } div_code_t;

    // ceil(2^RECIP_SHIFT / d), exact for every numerator below 2^NUM_W
    function automatic logic [RECIP_W-1:0] recip(input div_code_t code);
        logic [RECIP_W-1:0] val;
        unique case (code)
            DIV_19:  val = 23'd883012;
            DIV_100: val = 23'd167773;
            DIV_25:  val = 23'd671089;
            DIV_3:   val = 23'd5592406;
            DIV_30:  val = 23'd559241;
            DIV_7:   val = 23'd2396746;
            DIV_451: val = 23'd37201;
            DIV_31:  val = 23'd541201;
        endcase
        return val;
    endfunction

    function automatic logic [REM_W-1:0] divisor(input div_code_t code);
        logic [REM_W-1:0] val;
        unique case (code)
            DIV_19:  val = 9'd19;
            DIV_100: val = 9'd100;
            DIV_25:  val = 9'd25;
            DIV_3:   val = 9'd3;
            DIV_30:  val = 9'd30;
            DIV_7:   val = 9'd7;
            DIV_451: val = 9'd451;
            DIV_31:  val = 9'd31;
        endcase
        return val;
    endfunction

    // one step of the month walk
    typedef struct packed {
        doy_t n;
        mon_t m;
        logic leap;
    } walk_req_t;

    typedef struct packed {
        logic adv;
        doy_t n_next;
        mon_t m_next;
    } walk_rsp_t;

endpackage

[src/ehd_cdiv.sv]
// ----------------------------------------------------------------------------
// ehd_cdiv - shared divider by a selectable constant
// Quotient by reciprocal multiplication, remainder by multiply back and
// subtract. Two register stages: operand, then quotient.
// ----------------------------------------------------------------------------
module ehd_cdiv (
    input  logic                clk,
    input  ehd_pkg::num_t       num,
    input  ehd_pkg::div_code_t  code,
    output ehd_pkg::quo_t       quo,
    output ehd_pkg::rem_t       rem
);

    localparam int PROD_W = ehd_pkg::NUM_W + ehd_pkg::RECIP_W;

    ehd_pkg::num_t      num_s1_reg;
    ehd_pkg::div_code_t code_s1_reg;
    ehd_pkg::num_t      num_s2_reg;
    ehd_pkg::div_code_t code_s2_reg;
    ehd_pkg::quo_t      quo_s2_reg;
    logic [PROD_W-1:0]  prod;
    ehd_pkg::num_t      qd;

    // reciprocal product of the registered operand
    assign prod = {{ehd_pkg::RECIP_W{1'b0}}, num_s1_reg}
                * {{ehd_pkg::NUM_W{1'b0}}, ehd_pkg::recip(code_s1_reg)};

    // operand and quotient stages
    always_ff @(posedge clk)
    begin
        num_s1_reg  <= num;
        code_s1_reg <= code;
        num_s2_reg  <= num_s1_reg;
        code_s2_reg <= code_s1_reg;
        quo_s2_reg  <= prod[PROD_W-1 -: ehd_pkg::QUO_W];
    end

    // remainder from the registered quotient
    assign qd  = ehd_pkg::num_t'(quo_s2_reg)
               * ehd_pkg::num_t'(ehd_pkg::divisor(code_s2_reg));
    assign quo = quo_s2_reg;
    assign rem = ehd_pkg::REM_W'(num_s2_reg - qd);

endmodule

[src/ehd_mstep.sv]
// ----------------------------------------------------------------------------
// ehd_mstep - one step of the month walk
// Compares a day number with the length of the current month and gives the
// day number and month after stepping past it.
// ----------------------------------------------------------------------------
module ehd_mstep (
    input  ehd_pkg::walk_req_t req,
    output ehd_pkg::walk_rsp_t rsp
);

    ehd_pkg::doy_t len;

    // month length with the gregorian leap rule
    always_comb
    begin
        unique case (req.m) inside
            ehd_pkg::MONTH_FEB:
                len = req.leap ? ehd_pkg::doy_t'(29) : ehd_pkg::doy_t'(28);
            ehd_pkg::MONTH_APR, ehd_pkg::MONTH_JUN,
            ehd_pkg::MONTH_SEP, ehd_pkg::MONTH_NOV:
                len = ehd_pkg::doy_t'(30);
            default:
                len = ehd_pkg::doy_t'(31);
        endcase
    end

    // step past the month while the day number is beyond it
    assign rsp.adv    = (req.m < ehd_pkg::MONTH_DEC) && (req.n > len);
    assign rsp.n_next = req.n - len;
    assign rsp.m_next = ehd_pkg::mon_t'(req.m + 1'b1);

endmodule

[src/easter_holy_days_calculator_top.sv]
// ----------------------------------------------------------------------------
// easter_holy_days_calculator_top - holy days of one gregorian year
// Sequence: eight constant divisions through the shared divider, the S_DOY
// and S_LOAD setup states, a month walk of one month per cycle, then the
// S_DONE output state. Items are handled one at a time; a new item is taken
// the cycle after the result is registered, also while that result still
// waits.
// Reset: rst_n clears the sequencer and out_valid; no clearing pass.
// ----------------------------------------------------------------------------
module easter_holy_days_calculator_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [13:0]   year,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [4:0]    carnival_day,
    output logic [3:0]    carnival_month,
    output logic [4:0]    good_friday_day,
    output logic [3:0]    good_friday_month,
    output logic [4:0]    easter_day_of_month,
    output logic [3:0]    easter_month_number,
    output logic [4:0]    whitsun_day,
    output logic [3:0]    whitsun_month,
    output logic [4:0]    ascension_day_of_month,
    output logic [3:0]    ascension_month
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_DOY,
        S_LOAD,
        S_WALK,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_A,
        OP_B,
        OP_F,
        OP_G,
        OP_H,
        OP_L,
        OP_M,
        OP_BASE
    } op_t;

    typedef enum logic [1:0] {
        SEL_CARN,
        SEL_GF,
        SEL_WHIT,
        SEL_ASC
    } sel_t;

    state_t             state_reg;
    op_t                op_reg;
    logic [1:0]         phase_reg;
    sel_t               sel_reg;
    logic               out_valid_reg;

    logic [ehd_pkg::YEAR_W-1:0] year_reg;
    logic [4:0]         a_reg;
    logic [7:0]         b_reg;
    logic [6:0]         c_reg;
    logic [2:0]         f_reg;
    logic [7:0]         g_reg;
    logic [4:0]         h_reg;
    logic [2:0]         l_reg;
    logic               m_reg;
    ehd_pkg::day_t      e_day_reg;
    ehd_pkg::mon_t      e_mon_reg;
    logic               leap_reg;
    ehd_pkg::doy_t      doy_reg;
    ehd_pkg::doy_t      n_reg;
    ehd_pkg::mon_t      mon_reg;

    ehd_pkg::day_t      carn_day_reg;
    ehd_pkg::mon_t      carn_mon_reg;
    ehd_pkg::day_t      gf_day_reg;
    ehd_pkg::mon_t      gf_mon_reg;
    ehd_pkg::day_t      whit_day_reg;
    ehd_pkg::mon_t      whit_mon_reg;
    ehd_pkg::day_t      asc_day_reg;
    ehd_pkg::mon_t      asc_mon_reg;

    ehd_pkg::day_t      out_carn_day_reg;
    ehd_pkg::mon_t      out_carn_mon_reg;
    ehd_pkg::day_t      out_gf_day_reg;
    ehd_pkg::mon_t      out_gf_mon_reg;
    ehd_pkg::day_t      out_e_day_reg;
    ehd_pkg::mon_t      out_e_mon_reg;
    ehd_pkg::day_t      out_whit_day_reg;
    ehd_pkg::mon_t      out_whit_mon_reg;
    ehd_pkg::day_t      out_asc_day_reg;
    ehd_pkg::mon_t      out_asc_mon_reg;

    ehd_pkg::num_t      div_num;
    ehd_pkg::div_code_t div_code;
    ehd_pkg::quo_t      div_quo;
    ehd_pkg::rem_t      div_rem;
    ehd_pkg::num_t      a_n, b_n, d_n, e_n, f_n, g_n, h_n, i_n, k_n, l_n, m_n;

    logic               leap_next;
    ehd_pkg::doy_t      doy_next;
    ehd_pkg::walk_req_t walk_req;
    ehd_pkg::walk_rsp_t walk_rsp;
    sel_t               sel_next;
    ehd_pkg::doy_t      start_next;
    logic               div_last;
    logic               out_free;
    logic               accept;

    // start day number of a date, counted from 1 january
    function automatic ehd_pkg::doy_t start_n(input sel_t sel, input ehd_pkg::doy_t doy);
        ehd_pkg::doy_t n;
        unique case (sel)
            SEL_CARN:
                n = (doy > ehd_pkg::doy_t'(49)) ? doy - ehd_pkg::doy_t'(49)
                                                : ehd_pkg::doy_t'(1);
            SEL_GF:
                n = (doy > ehd_pkg::doy_t'(2)) ? doy - ehd_pkg::doy_t'(2)
                                               : ehd_pkg::doy_t'(1);
            SEL_WHIT:
                n = doy + ehd_pkg::doy_t'(49);
            SEL_ASC:
                n = doy + ehd_pkg::doy_t'(39);
        endcase
        if (n == ehd_pkg::doy_t'(0))
        begin
            n = ehd_pkg::doy_t'(1);
        end
        return n;
    endfunction

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign div_last = (phase_reg == 2'(ehd_pkg::DIV_LAT));

    // computus terms widened for the operand mux
    assign a_n = ehd_pkg::num_t'(a_reg);
    assign b_n = ehd_pkg::num_t'(b_reg);
    assign d_n = ehd_pkg::num_t'(b_reg[7:2]);
    assign e_n = ehd_pkg::num_t'(b_reg[1:0]);
    assign f_n = ehd_pkg::num_t'(f_reg);
    assign g_n = ehd_pkg::num_t'(g_reg);
    assign h_n = ehd_pkg::num_t'(h_reg);
    assign i_n = ehd_pkg::num_t'(c_reg[6:2]);
    assign k_n = ehd_pkg::num_t'(c_reg[1:0]);
    assign l_n = ehd_pkg::num_t'(l_reg);
    assign m_n = ehd_pkg::num_t'(m_reg);

    // divider operand and divisor for each computus step
    always_comb
    begin
        unique case (op_reg)
            OP_A:
            begin
                div_num  = ehd_pkg::num_t'(year_reg);
                div_code = ehd_pkg::DIV_19;
            end
            OP_B:
            begin
                div_num  = ehd_pkg::num_t'(year_reg);
                div_code = ehd_pkg::DIV_100;
            end
            OP_F:
            begin
                div_num  = b_n + ehd_pkg::num_t'(8);
                div_code = ehd_pkg::DIV_25;
            end
            OP_G:
            begin
                div_num  = b_n - f_n + ehd_pkg::num_t'(1);
                div_code = ehd_pkg::DIV_3;
            end
            OP_H:
            begin
                div_num  = ehd_pkg::num_t'(19) * a_n + b_n + ehd_pkg::num_t'(135)
                         - d_n - g_n;
                div_code = ehd_pkg::DIV_30;
            end
            OP_L:
            begin
                div_num  = ehd_pkg::num_t'(32) + (e_n << 1) + (i_n << 1) - h_n - k_n;
                div_code = ehd_pkg::DIV_7;
            end
            OP_M:
            begin
                div_num  = a_n + ehd_pkg::num_t'(11) * h_n + ehd_pkg::num_t'(22) * l_n;
                div_code = ehd_pkg::DIV_451;
            end
            OP_BASE:
            begin
                div_num  = h_n + l_n + ehd_pkg::num_t'(114) - ehd_pkg::num_t'(7) * m_n;
                div_code = ehd_pkg::DIV_31;
            end
        endcase
    end

    ehd_cdiv u_cdiv (
        .clk  (clk),
        .num  (div_num),
        .code (div_code),
        .quo  (div_quo),
        .rem  (div_rem)
    );

    // leap rule and day of year of easter
    assign leap_next = (year_reg[1:0] == 2'b00)
                    && !((c_reg == 7'd0) && (b_reg[1:0] != 2'b00));
    assign doy_next  = ((e_mon_reg == ehd_pkg::MONTH_APR) ? ehd_pkg::doy_t'(90)
                                                          : ehd_pkg::doy_t'(59))
                     + ehd_pkg::doy_t'(leap_next) + ehd_pkg::doy_t'(e_day_reg);

    // month walk
    assign walk_req.n    = n_reg;
    assign walk_req.m    = mon_reg;
    assign walk_req.leap = leap_reg;

    ehd_mstep u_mstep (
        .req (walk_req),
        .rsp (walk_rsp)
    );

    assign sel_next   = sel_t'(sel_reg + 1'b1);
    assign start_next = start_n(sel_next, doy_reg);

    // sequencer and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_A;
            phase_reg     <= 2'd0;
            sel_reg       <= SEL_CARN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_DIV;
                        op_reg    <= OP_A;
                        phase_reg <= 2'd0;
                    end
                end
                S_DIV:
                begin
                    if (div_last)
                    begin
                        phase_reg <= 2'd0;
                        if (op_reg == OP_BASE)
                        begin
                            state_reg <= S_DOY;
                        end
                        else
                        begin
                            op_reg <= op_t'(op_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 2'd1;
                    end
                end
                S_DOY:
                begin
                    state_reg <= S_LOAD;
                    sel_reg   <= SEL_CARN;
                end
                S_LOAD:
                begin
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (!walk_rsp.adv)
                    begin
                        if (sel_reg == SEL_ASC)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            sel_reg <= sel_next;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            year_reg <= year;
        end

        // capture of each division result
        if (state_reg == S_DIV && div_last)
        begin
            unique case (op_reg)
                OP_A:    a_reg <= div_rem[4:0];
                OP_B:
                begin
                    b_reg <= div_quo[7:0];
                    c_reg <= div_rem[6:0];
                end
                OP_F:    f_reg <= div_quo[2:0];
                OP_G:    g_reg <= div_quo[7:0];
                OP_H:    h_reg <= div_rem[4:0];
                OP_L:    l_reg <= div_rem[2:0];
                OP_M:    m_reg <= div_quo[0];
                OP_BASE:
                begin
                    e_day_reg <= div_rem[4:0] + 5'd1;
                    e_mon_reg <= div_quo[3:0];
                end
            endcase
        end

        if (state_reg == S_DOY)
        begin
            leap_reg <= leap_next;
            doy_reg  <= doy_next;
        end

        if (state_reg == S_LOAD)
        begin
            n_reg   <= start_n(SEL_CARN, doy_reg);
            mon_reg <= ehd_pkg::MONTH_JAN;
        end

        // walk one month per cycle, then store the date and load the next
        if (state_reg == S_WALK)
        begin
            if (walk_rsp.adv)
            begin
                n_reg   <= walk_rsp.n_next;
                mon_reg <= walk_rsp.m_next;
            end
            else
            begin
                unique case (sel_reg)
                    SEL_CARN:
                    begin
                        carn_day_reg <= n_reg[4:0];
                        carn_mon_reg <= mon_reg;
                    end
                    SEL_GF:
                    begin
                        gf_day_reg <= n_reg[4:0];
                        gf_mon_reg <= mon_reg;
                    end
                    SEL_WHIT:
                    begin
                        whit_day_reg <= n_reg[4:0];
                        whit_mon_reg <= mon_reg;
                    end
                    SEL_ASC:
                    begin
                        asc_day_reg <= n_reg[4:0];
                        asc_mon_reg <= mon_reg;
                    end
                endcase
                n_reg   <= start_next;
                mon_reg <= ehd_pkg::MONTH_JAN;
            end
        end

        // output item register
        if (state_reg == S_DONE && out_free)
        begin
            out_carn_day_reg <= carn_day_reg;
            out_carn_mon_reg <= carn_mon_reg;
            out_gf_day_reg   <= gf_day_reg;
            out_gf_mon_reg   <= gf_mon_reg;
            out_e_day_reg    <= e_day_reg;
            out_e_mon_reg    <= e_mon_reg;
            out_whit_day_reg <= whit_day_reg;
            out_whit_mon_reg <= whit_mon_reg;
            out_asc_day_reg  <= asc_day_reg;
            out_asc_mon_reg  <= asc_mon_reg;
        end
    end

    assign out_valid              = out_valid_reg;
    assign carnival_day           = out_carn_day_reg;
    assign carnival_month         = out_carn_mon_reg;
    assign good_friday_day        = out_gf_day_reg;
    assign good_friday_month      = out_gf_mon_reg;
    assign easter_day_of_month    = out_e_day_reg;
    assign easter_month_number    = out_e_mon_reg;
    assign whitsun_day            = out_whit_day_reg;
    assign whitsun_month          = out_whit_mon_reg;
    assign ascension_day_of_month = out_asc_day_reg;
    assign ascension_month        = out_asc_mon_reg;

`ifndef SYNTHESIS
    // busy after an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input taken again right after an accept");

    // a finished result waits while the output is blocked
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> state_reg == S_DONE)
        else $error("finished result left while output blocked");

    // the walk never passes december
    a_walk_month: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (mon_reg <= ehd_pkg::MONTH_DEC))
        else $error("month walk beyond december");

    // easter always lands on a real day in march or april
    a_easter_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((easter_month_number == ehd_pkg::MONTH_MAR
                     || easter_month_number == ehd_pkg::MONTH_APR)
                     && easter_day_of_month != 5'd0))
        else $error("easter date out of range");
`endif

endmodule

[tb/tb_easter_holy_days_calculator_top.sv]
// ----------------------------------------------------------------------------
// tb_easter_holy_days_calculator_top - holy days calculator testbench
// Sends years through the valid/ready input and predicts carnival, good
// friday, easter, whitsun and ascension dates for each accepted item. Every
// accepted result is checked against the oldest prediction. Runs directed
// years, then random years under changing sender and receiver idling, and a
// long output hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb_easter_holy_days_calculator_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_WAIT  = 60;
    localparam int MAX_REPORTS  = 10;
    localparam int ITEMS_PHASE  = 380;

    // one set of dates for one year
    typedef struct packed {
        logic [ehd_pkg::YEAR_W-1:0] year;
        ehd_pkg::day_t              carn_day;
        ehd_pkg::mon_t              carn_mon;
        ehd_pkg::day_t              gf_day;
        ehd_pkg::mon_t              gf_mon;
        ehd_pkg::day_t              pasch_day;
        ehd_pkg::mon_t              pasch_mon;
        ehd_pkg::day_t              whit_day;
        ehd_pkg::mon_t              whit_mon;
        ehd_pkg::day_t              asc_day;
        ehd_pkg::mon_t              asc_mon;
    } holy_days_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [13:0]       year;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [4:0]        carnival_day;
    logic [3:0]        carnival_month;
    logic [4:0]        good_friday_day;
    logic [3:0]        good_friday_month;
    logic [4:0]        easter_day_of_month;
    logic [3:0]        easter_month_number;
    logic [4:0]        whitsun_day;
    logic [3:0]        whitsun_month;
    logic [4:0]        ascension_day_of_month;
    logic [3:0]        ascension_month;

    holy_days_t        pending_dates[$];
    int                mismatch_count = 0;
    int                cycle_count = 0;
    int                hold_until = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;

    easter_holy_days_calculator_top dut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .in_valid               (in_valid),
        .in_ready               (in_ready),
        .year                   (year),
        .out_valid              (out_valid),
        .out_ready              (out_ready),
        .carnival_day           (carnival_day),
        .carnival_month         (carnival_month),
        .good_friday_day        (good_friday_day),
        .good_friday_month      (good_friday_month),
        .easter_day_of_month    (easter_day_of_month),
        .easter_month_number    (easter_month_number),
        .whitsun_day            (whitsun_day),
        .whitsun_month          (whitsun_month),
        .ascension_day_of_month (ascension_day_of_month),
        .ascension_month        (ascension_month)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_easter_holy_days_calculator_top failed");
            $finish;
        end
    end

    // gregorian leap rule
    function automatic bit is_leap(input int unsigned y);
        if (y % 4 != 0)
            return 1'b0;
        if (y % 100 == 0 && y % 400 != 0)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic int unsigned month_days(input int unsigned y,
                                               input ehd_pkg::mon_t m);
        case (m)
            ehd_pkg::MONTH_FEB: return is_leap(y) ? 29 : 28;
            ehd_pkg::MONTH_APR, ehd_pkg::MONTH_JUN,
            ehd_pkg::MONTH_SEP, ehd_pkg::MONTH_NOV: return 30;
            default: return 31;
        endcase
    endfunction

    // day number of the year back to day and month, stops at december
    function automatic void split_day_number(input int unsigned num, input int unsigned y,
                                             output ehd_pkg::day_t d,
                                             output ehd_pkg::mon_t m);
        int unsigned   n;
        ehd_pkg::mon_t mon;
        n   = (num < 1) ? 1 : num;
        mon = ehd_pkg::MONTH_JAN;
        while (mon < ehd_pkg::MONTH_DEC && n > month_days(y, mon))
        begin
            n   = n - month_days(y, mon);
            mon = mon + 1'b1;
        end
        d = ehd_pkg::day_t'(n);
        m = mon;
    endfunction

    // all five dates of one year
    function automatic holy_days_t holy_days_of(input logic [ehd_pkg::YEAR_W-1:0] yr);
        int unsigned y, a, b, c, d, e, f, g, h, i, k, l, corr;
        int unsigned base, e_day, e_mon, doy;
        holy_days_t  r;
        y = yr;
        // easter by the anonymous gregorian computus
        a    = y % 19;
        b    = y / 100;
        c    = y % 100;
        d    = b / 4;
        e    = b % 4;
        f    = (b + 8) / 25;
        g    = (b - f + 1) / 3;
        h    = (19 * a + b + 135 - d - g) % 30;
        i    = c / 4;
        k    = c % 4;
        l    = (32 + 2 * e + 2 * i - h - k) % 7;
        corr = (a + 11 * h + 22 * l) / 451;
        base = h + l + 114 - 7 * corr;
        e_day = base % 31 + 1;
        e_mon = base / 31;
        // easter as a day number of the year
        doy = e_day;
        for (int unsigned m = 1; m < e_mon && m <= ehd_pkg::MONTH_DEC; m++)
            doy += month_days(y, ehd_pkg::mon_t'(m));
        r.year      = yr;
        r.pasch_day = ehd_pkg::day_t'(e_day);
        r.pasch_mon = ehd_pkg::mon_t'(e_mon);
        split_day_number((doy > 49) ? doy - 49 : 1, y, r.carn_day, r.carn_mon);
        split_day_number((doy > 2) ? doy - 2 : 1, y, r.gf_day, r.gf_mon);
        split_day_number(doy + 49, y, r.whit_day, r.whit_mon);
        split_day_number(doy + 39, y, r.asc_day, r.asc_mon);
        return r;
    endfunction

    function automatic string date_text(input holy_days_t r);
        return $sformatf("carn %0d/%0d gf %0d/%0d easter %0d/%0d whit %0d/%0d asc %0d/%0d",
                         r.carn_day, r.carn_mon, r.gf_day, r.gf_mon, r.pasch_day,
                         r.pasch_mon, r.whit_day, r.whit_mon, r.asc_day, r.asc_mon);
    endfunction

    // predict on input accept, check on output accept
    always @(posedge clk)
    begin
        holy_days_t want;
        holy_days_t seen;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pending_dates.push_back(holy_days_of(year));
            if (out_valid && out_ready)
            begin
                seen = '{year: '0,
                         carn_day: carnival_day, carn_mon: carnival_month,
                         gf_day: good_friday_day, gf_mon: good_friday_month,
                         pasch_day: easter_day_of_month, pasch_mon: easter_month_number,
                         whit_day: whitsun_day, whit_mon: whitsun_month,
                         asc_day: ascension_day_of_month, asc_mon: ascension_month};
                if (pending_dates.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("unexpected result item: %s", date_text(seen));
                    mismatch_count++;
                end
                else
                begin
                    want = pending_dates.pop_front();
                    if (seen.carn_day !== want.carn_day || seen.carn_mon !== want.carn_mon
                        || seen.gf_day !== want.gf_day || seen.gf_mon !== want.gf_mon
                        || seen.pasch_day !== want.pasch_day
                        || seen.pasch_mon !== want.pasch_mon
                        || seen.whit_day !== want.whit_day || seen.whit_mon !== want.whit_mon
                        || seen.asc_day !== want.asc_day || seen.asc_mon !== want.asc_mon)
                    begin
                        if (mismatch_count < MAX_REPORTS)
                            $display("year %0d mismatch\n  expected %s\n  actual   %s",
                                     want.year, date_text(want), date_text(seen));
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // output ready: random stalls, plus a long hold-off window
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (cycle_count < hold_until)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int idle_gap();
        int n;
        n = 0;
        while (n < 40 && $urandom_range(99) < send_idle_pct)
            n++;
        return n;
    endfunction

    // one item through the input handshake, valid stays high afterwards
    task automatic send_year(input logic [13:0] y);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        year     <= y;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // sender pauses until every expected result is back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_dates.size() != 0);
    endtask

    function automatic logic [13:0] pick_year();
        case ($urandom_range(9))
            6, 7:    return 14'($urandom_range(16383, 0));
            8:       return 14'($urandom_range(99, 15) * 100);
            9:
            begin
                case ($urandom_range(3))
                    0:       return 14'($urandom_range(1590, 1583));
                    1:       return 14'($urandom_range(9999, 9990));
                    2:       return 14'($urandom_range(10, 0));
                    default: return 14'($urandom_range(16383, 16370));
                endcase
            end
            default: return 14'($urandom_range(9999, 1583));
        endcase
    endfunction

    // field extremes, century leap rules, earliest and latest easter
    task automatic test_directed_years();
        logic [13:0] years [22] = '{14'd0, 14'd16383, 14'd1583, 14'd9999, 14'd1600,
                                    14'd1700, 14'd1900, 14'd2000, 14'd2100, 14'd2400,
                                    14'd1818, 14'd2285, 14'd1943, 14'd2038, 14'd2008,
                                    14'd2011, 14'd1913, 14'd2024, 14'd2025, 14'd10000,
                                    14'd8192, 14'd12345};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (years[j])
            send_year(years[j]);
        wait_for_results();
    endtask

    task automatic test_random_years(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_year(pick_year());
        wait_for_results();
    endtask

    // long output hold-off while input keeps offering items
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_until     = cycle_count + HOLD_CYCLES;
        repeat (12)
            send_year(pick_year());
        wait_for_results();
    endtask

    // test sequence
    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        year     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_years();
        test_random_years(ITEMS_PHASE, 0, 0);
        test_random_years(ITEMS_PHASE, 67, 0);
        test_random_years(ITEMS_PHASE, 0, 67);
        test_output_backpressure();
        test_random_years(ITEMS_PHASE, 30, 30);

        repeat (SETTLE_WAIT) @(posedge clk);
        if (mismatch_count == 0 && pending_dates.size() == 0)
            $display("tb_easter_holy_days_calculator_top passed");
        else
            $display("tb_easter_holy_days_calculator_top failed");
        $finish;
    end

endmodule
